// ===== rtl/prq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared widths, request and result codes, and cell control types for the
// priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;

  localparam int ID_W    = 16;
  localparam int PRIO_W  = 7;
  localparam int STATE_W = 4;
  localparam int ACT_W   = 2;
  localparam int CODE_W  = 3;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

  localparam logic [CODE_W-1:0] OUT_INSERTED  = 3'd0;
  localparam logic [CODE_W-1:0] OUT_DUPLICATE = 3'd1;
  localparam logic [CODE_W-1:0] OUT_NOT_READY = 3'd2;
  localparam logic [CODE_W-1:0] OUT_FULL      = 3'd3;
  localparam logic [CODE_W-1:0] OUT_REMOVED   = 3'd4;
  localparam logic [CODE_W-1:0] OUT_NOT_FOUND = 3'd5;
  localparam logic [CODE_W-1:0] OUT_ENTRY     = 3'd6;
  localparam logic [CODE_W-1:0] OUT_EMPTY     = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
  } cell_ctrl_t;

endpackage

// ===== rtl/priority_ready_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_core
// Ready queue of process entries in ascending priority order, built as a
// row of slot cells that compare in parallel and shift together.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_tuser = action (insert, remove, list),
//   s_tdata = proc_id [15:0], priority_req [22:16], proc_state [26:23].
//   m_* carries results: m_tuser = outcome, m_tdata = out_id [15:0],
//   out_priority [22:16], m_tlast marks the final result of a request.
//   A request is taken only while the core is idle. Insert and remove give
//   one result, registered after the request executes in ST_EXEC; the slot
//   row compares the id and priority in every cell at once, and the next
//   request is taken once the core is back in idle. A list gives its first
//   result from ST_LIST after ST_EXEC and then one entry per cycle while
//   m_tready does not stall, read from the slot row in head-to-tail order;
//   an empty queue gives one result. An unused action gives no result.
//   Reset empties the queue at once; slot contents are not cleared.
//   A stalled m_tready holds the result register; one more request may be
//   taken, and it waits until the result register is free.
// ----------------------------------------------------------------------------
module priority_ready_queue_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // proc_id, priority_req, proc_state, zero pad
  input  logic [prq_pkg::IN_DATA_W-1:0]   s_tdata,
  // action
  input  logic [prq_pkg::ACT_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_id, out_priority, zero pad
  output logic [prq_pkg::OUT_DATA_W-1:0]  m_tdata,
  // outcome
  output logic [prq_pkg::CODE_W-1:0]      m_tuser,
  output logic                            m_tlast
);
  import prq_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] list_idx, list_idx_next;

  logic [ACT_W-1:0]   req_action;
  logic [ID_W-1:0]    req_id;
  logic [PRIO_W-1:0]  req_prio;
  logic [STATE_W-1:0] req_state;

  cell_ctrl_t ctrl;
  logic load_out;
  logic [CODE_W-1:0] out_code_next;
  logic [ID_W-1:0]   out_id_next;
  logic [PRIO_W-1:0] out_prio_next;
  logic              out_last_next;
  logic out_free;
  logic full;
  logic any_match;
  logic [CNT_W-1:0] shown;
  logic list_last;

  logic [ID_W-1:0]   cell_id   [CAPACITY];
  logic [PRIO_W-1:0] cell_prio [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY:0]   hit;

  assign hit[0]    = 1'b0;
  assign any_match = hit[CAPACITY];
  assign full      = (count >= CNT_W'(CAPACITY));
  assign out_free  = !m_tvalid || m_tready;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic              l_occ, l_ge;
      logic [ID_W-1:0]   l_id, r_id;
      logic [PRIO_W-1:0] l_prio, r_prio;

      assign cell_occ[i] = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        assign l_occ  = 1'b1;
        assign l_ge   = 1'b0;
        assign l_id   = cell_id[i];
        assign l_prio = cell_prio[i];
      end else begin : g_body
        assign l_occ  = cell_occ[i-1];
        assign l_ge   = cell_ge[i-1];
        assign l_id   = cell_id[i-1];
        assign l_prio = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_id   = cell_id[i];
        assign r_prio = cell_prio[i];
      end else begin : g_mid
        assign r_id   = cell_id[i+1];
        assign r_prio = cell_prio[i+1];
      end

      prq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occ        (cell_occ[i]),
        .left_occ   (l_occ),
        .left_ge    (l_ge),
        .left_id    (l_id),
        .left_prio  (l_prio),
        .right_id   (r_id),
        .right_prio (r_prio),
        .hit_in     (hit[i]),
        .id         (cell_id[i]),
        .prio       (cell_prio[i]),
        .ge         (cell_ge[i]),
        .match      (cell_match[i]),
        .hit_out    (hit[i+1])
      );
    end
  endgenerate

  always_comb begin
    if (int'(count) > MAX_RESULTS) begin
      shown = CNT_W'(MAX_RESULTS);
    end else begin
      shown = count;
    end
  end

  assign list_last = ((CNT_W'(list_idx) + 1'b1) == shown);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (req_action)
          ACT_INSERT, ACT_REMOVE: begin
            if (out_free) begin
              state_next = ST_IDLE;
            end
          end
          ACT_LIST: begin
            if (count == '0) begin
              if (out_free) begin
                state_next = ST_IDLE;
              end
            end else begin
              state_next = ST_LIST;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_LIST: begin
        if (out_free && list_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_tready      = 1'b0;
    ctrl.op       = CELL_HOLD;
    ctrl.id       = req_id;
    ctrl.prio     = req_prio;
    load_out      = 1'b0;
    out_code_next = OUT_INSERTED;
    out_id_next   = req_id;
    out_prio_next = '0;
    out_last_next = 1'b1;
    count_next    = count;
    list_idx_next = list_idx;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EXEC: begin
        list_idx_next = '0;
        case (req_action)
          ACT_INSERT: begin
            load_out = out_free;
            if (full) begin
              out_code_next = OUT_FULL;
            end else if (req_state != '0) begin
              out_code_next = OUT_NOT_READY;
            end else if (any_match) begin
              out_code_next = OUT_DUPLICATE;
            end else begin
              out_code_next = OUT_INSERTED;
              if (out_free) begin
                ctrl.op    = CELL_INSERT;
                count_next = count + 1'b1;
              end
            end
          end
          ACT_REMOVE: begin
            load_out = out_free;
            if (any_match) begin
              out_code_next = OUT_REMOVED;
              if (out_free) begin
                ctrl.op    = CELL_REMOVE;
                count_next = count - 1'b1;
              end
            end else begin
              out_code_next = OUT_NOT_FOUND;
            end
          end
          ACT_LIST: begin
            if (count == '0) begin
              load_out      = out_free;
              out_code_next = OUT_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end
      ST_LIST: begin
        load_out      = out_free;
        out_code_next = OUT_ENTRY;
        out_id_next   = cell_id[list_idx];
        out_prio_next = cell_prio[list_idx];
        out_last_next = list_last;
        if (out_free) begin
          list_idx_next = list_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      list_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= s_tuser;
      req_id     <= s_tdata[ID_W-1:0];
      req_prio   <= s_tdata[ID_W+PRIO_W-1:ID_W];
      req_state  <= s_tdata[ID_W+PRIO_W+STATE_W-1:ID_W+PRIO_W];
    end
    if (load_out) begin
      m_tuser <= out_code_next;
      m_tdata <= {{(OUT_DATA_W-ID_W-PRIO_W){1'b0}}, out_prio_next, out_id_next};
      m_tlast <= out_last_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("queue count beyond capacity");

  a_unique_ids: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("id found in more than one slot");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted request not executed");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (load_out && (state == ST_EXEC) && (req_action == ACT_INSERT)
      && (out_code_next == OUT_INSERTED))
    |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the queue");
`endif

endmodule

// ===== rtl/prq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One queue slot: holds an id and priority, compares them with the request
// and shifts toward or away from the head together with its neighbors.
// ----------------------------------------------------------------------------
module prq_cell (
  input  logic                        clk,
  input  prq_pkg::cell_ctrl_t         ctrl,
  input  logic                        occ,
  input  logic                        left_occ,
  input  logic                        left_ge,
  input  logic [prq_pkg::ID_W-1:0]    left_id,
  input  logic [prq_pkg::PRIO_W-1:0]  left_prio,
  input  logic [prq_pkg::ID_W-1:0]    right_id,
  input  logic [prq_pkg::PRIO_W-1:0]  right_prio,
  input  logic                        hit_in,
  output logic [prq_pkg::ID_W-1:0]    id,
  output logic [prq_pkg::PRIO_W-1:0]  prio,
  output logic                        ge,
  output logic                        match,
  output logic                        hit_out
);
  import prq_pkg::*;

  logic ins_load;

  assign ge       = occ && (prio >= ctrl.prio);
  assign match    = occ && (id == ctrl.id);
  assign hit_out  = hit_in || match;
  // slot takes a value if it shifts or is the first free slot
  assign ins_load = ge || (!occ && left_occ);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (ins_load) begin
          if (left_ge) begin
            id   <= left_id;
            prio <= left_prio;
          end else begin
            id   <= ctrl.id;
            prio <= ctrl.prio;
          end
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          id   <= right_id;
          prio <= right_prio;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
